>>> design/cth_pkg.sv
// ----------------------------------------------------------------------------
// Compressor thermostat package
// Shared types, register indexes and constants of the thermostat control.
// ----------------------------------------------------------------------------
package cth_pkg;

  localparam int TEMP_W      = 12;
  localparam int CNT_W       = 16;
  localparam int STEP_W      = 3;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int S_TDATA_W   = 32;
  localparam int M_TDATA_W   = 24;

  localparam int TICKS_PER_SECOND_DEF = 10;

  // Highest air step is STEP_COUNT-1
  localparam int STEP_COUNT = 5;
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(STEP_COUNT - 1);

  localparam logic [STEP_W-1:0] STEP_FAULT = 3'd0;
  localparam logic [STEP_W-1:0] STEP_COOL  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MILD  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_WARM  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_HOT   = 3'd4;

  // Air band limits in 0.1 C
  localparam logic signed [TEMP_W-1:0] AIR_LIMIT_COOL = 12'sd100;
  localparam logic signed [TEMP_W-1:0] AIR_LIMIT_MILD = 12'sd200;
  localparam logic signed [TEMP_W-1:0] AIR_LIMIT_WARM = 12'sd300;

  localparam logic signed [TEMP_W-1:0] START_NORMAL_RST = 12'sd80;
  localparam logic signed [TEMP_W-1:0] START_SAVING_RST = 12'sd100;
  localparam logic signed [TEMP_W-1:0] STOP_TEMP_RST    = 12'sd60;
  localparam logic signed [TEMP_W-1:0] ICE_GUARD_RST    = 12'sd10;
  localparam logic [CNT_W-1:0] OVERRUN_MILD_RST  = 16'd9000;
  localparam logic [CNT_W-1:0] OVERRUN_HOT_RST   = 16'd12000;
  localparam logic [CNT_W-1:0] RESTART_DELAY_RST = 16'd300;
  localparam logic [CNT_W-1:0] MAX_ON_TIME_RST   = 16'd7200;

  localparam logic [1:0] POWER_NORMAL = 2'd0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_START_NORMAL  = 3'd0,
    REG_START_SAVING  = 3'd1,
    REG_STOP_TEMP     = 3'd2,
    REG_OVERRUN_MILD  = 3'd3,
    REG_OVERRUN_HOT   = 3'd4,
    REG_RESTART_DELAY = 3'd5,
    REG_MAX_ON_TIME   = 3'd6,
    REG_ICE_GUARD     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] start_temp_normal;
    logic signed [TEMP_W-1:0] start_temp_saving;
    logic signed [TEMP_W-1:0] stop_temp;
    logic [CNT_W-1:0]         overrun_mild;
    logic [CNT_W-1:0]         overrun_hot;
    logic [CNT_W-1:0]         restart_delay;
    logic [CNT_W-1:0]         max_on_time;
    logic signed [TEMP_W-1:0] ice_guard_temp;
  } cfg_t;

  // Last member sits in the lowest bits, matching the tdata layout
  typedef struct packed {
    logic signed [TEMP_W-1:0] air_temp;
    logic signed [TEMP_W-1:0] cold_temp;
    logic [1:0]               power_mode;
    logic                     air_fault;
    logic                     cold_fault;
    logic                     fill_done;
    logic                     manual_test;
    logic                     cold_enabled;
  } tick_t;

  typedef struct packed {
    logic [CNT_W-1:0]  overrun_left;
    logic              max_on_reached;
    logic              restart_ready;
    logic [STEP_W-1:0] run_step;
    logic              compressor_on;
  } result_t;

  localparam int TICK_W   = $bits(tick_t);
  localparam int RESULT_W = $bits(result_t);

endpackage

>>> design/cth_ctrl.sv
// ----------------------------------------------------------------------------
// Thermostat control core
// Holds the controller state and works out one tick in a single pass:
// seconds counters first, then the start/stop decision.
// ----------------------------------------------------------------------------
module cth_ctrl #(
  parameter int TICKS_PER_SECOND = cth_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  cth_pkg::tick_t  tick,
  input  cth_pkg::cfg_t   cfg,
  output cth_pkg::result_t res
);

  localparam int PW = $clog2(TICKS_PER_SECOND + 1);
  localparam logic [PW-1:0] TPS = PW'(TICKS_PER_SECOND);

  logic [PW-1:0]                 prescaler, prescaler_next, pre_inc;
  logic                          running, running_next;
  logic [cth_pkg::CNT_W-1:0]     off_secs, off_secs_next, off_mid;
  logic [cth_pkg::CNT_W-1:0]     on_secs, on_secs_next;
  logic [cth_pkg::CNT_W-1:0]     overrun, overrun_next;
  logic [cth_pkg::STEP_W-1:0]    step, step_next, step_class;
  logic                          second;
  logic signed [cth_pkg::TEMP_W-1:0] start_thr;

  // Air band classification, saturated to the top step
  always_comb begin
    logic [cth_pkg::STEP_W-1:0] s;
    if (tick.air_fault) begin
      s = cth_pkg::STEP_FAULT;
    end else if (tick.air_temp < cth_pkg::AIR_LIMIT_COOL) begin
      s = cth_pkg::STEP_COOL;
    end else if (tick.air_temp < cth_pkg::AIR_LIMIT_MILD) begin
      s = cth_pkg::STEP_MILD;
    end else if (tick.air_temp < cth_pkg::AIR_LIMIT_WARM) begin
      s = cth_pkg::STEP_WARM;
    end else begin
      s = cth_pkg::STEP_HOT;
    end
    step_class = (s > cth_pkg::STEP_MAX) ? cth_pkg::STEP_MAX : s;
  end

  assign start_thr = (tick.power_mode == cth_pkg::POWER_NORMAL) ?
                     cfg.start_temp_normal : cfg.start_temp_saving;

  // Seconds counters, using the compressor state from before the tick
  always_comb begin
    pre_inc        = prescaler + PW'(1);
    second         = (pre_inc >= TPS);
    prescaler_next = second ? '0 : pre_inc;
    off_mid        = off_secs;
    on_secs_next   = on_secs;
    if (second) begin
      if (!running) begin
        if (off_secs < cfg.restart_delay) begin
          off_mid = off_secs + 16'd1;
        end
        on_secs_next = '0;
      end else if (on_secs < cfg.max_on_time) begin
        if (tick.cold_temp < cfg.ice_guard_temp) begin
          on_secs_next = cfg.max_on_time;
        end else begin
          on_secs_next = on_secs + 16'd1;
        end
      end
    end
  end

  // Start/stop decision
  always_comb begin
    logic force_off;
    force_off     = 1'b0;
    running_next  = running;
    off_secs_next = off_mid;
    overrun_next  = overrun;
    step_next     = step;
    if (!tick.manual_test) begin
      priority if (!tick.cold_enabled) begin
        force_off = 1'b1;
      end else if (off_mid < cfg.restart_delay) begin
        overrun_next = '0;
        running_next = 1'b0;
      end else if (on_secs_next >= cfg.max_on_time) begin
        force_off = 1'b1;
      end else if (!tick.fill_done) begin
        force_off = 1'b1;
      end else begin
        step_next = step_class;
        if (tick.cold_fault) begin
          force_off = 1'b1;
        end else if (tick.cold_temp > start_thr) begin
          if (!running) begin
            running_next = 1'b1;
            if (step_class == cth_pkg::STEP_COOL || step_class == cth_pkg::STEP_MILD) begin
              overrun_next = cfg.overrun_mild;
            end else if (step_class >= cth_pkg::STEP_WARM) begin
              overrun_next = cfg.overrun_hot;
            end else begin
              overrun_next = '0;
            end
          end
        end else if (tick.cold_temp < cfg.stop_temp) begin
          if (running) begin
            if (overrun == '0) begin
              off_secs_next = '0;
              running_next  = 1'b0;
            end else begin
              overrun_next = overrun - 16'd1;
            end
          end
        end
      end
    end
    // Forced stop only acts on a running compressor
    if (force_off && running) begin
      running_next  = 1'b0;
      off_secs_next = '0;
      overrun_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescaler <= '0;
      running   <= 1'b0;
      off_secs  <= '0;
      on_secs   <= '0;
      overrun   <= '0;
      step      <= cth_pkg::STEP_FAULT;
    end else if (en) begin
      prescaler <= prescaler_next;
      running   <= running_next;
      off_secs  <= off_secs_next;
      on_secs   <= on_secs_next;
      overrun   <= overrun_next;
      step      <= step_next;
    end
  end

  always_comb begin
    res.compressor_on  = running_next;
    res.run_step       = step_next;
    res.restart_ready  = (off_secs_next >= cfg.restart_delay);
    res.max_on_reached = (on_secs_next >= cfg.max_on_time);
    res.overrun_left   = overrun_next;
  end

  a_prescaler_range: assert property (@(posedge clk) disable iff (rst)
    prescaler < TPS)
    else $error("prescaler out of range");

  a_overrun_needs_run: assert property (@(posedge clk) disable iff (rst)
    overrun != '0 |-> running)
    else $error("overrun pending while compressor off");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= cth_pkg::STEP_MAX)
    else $error("air step above top step");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable({prescaler, running, off_secs, on_secs, overrun, step}))
    else $error("state moved without a tick");

endmodule

>>> design/compressor_thermostat_control.sv
// ----------------------------------------------------------------------------
// Compressor thermostat control
// Tick-driven compressor start/stop with restart delay, on-time cap and
// overrun, plus its configuration registers and stream handshakes.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel is one 100 ms tick carrying the enable and
//   fault flags and the cold and air temperatures. Each tick yields exactly
//   one result on the m_ channel: compressor drive, air step, restart-ready,
//   on-time-cap flag and the remaining overrun ticks.
//   A tick is taken into an input register, processed in one pass by the
//   control core and then registered in the output register once that is
//   free, where the receiver takes it. One tick per clock is sustained while
//   the receiver does not stall; the limit is the state update in the core.
//   When the receiver stalls, the result holds in the output register, the
//   input register still takes one more tick, then s_tready drops until
//   m_tready returns.
//   Settings are written on cfg_wen/cfg_addr/cfg_wdata while no tick is in
//   flight; temperatures use the low 12 bits of cfg_wdata.
//   Synchronous reset clears the compressor state and counters, empties both
//   registers and restores the default settings. No clearing pass is needed.
// ----------------------------------------------------------------------------
module compressor_thermostat_control #(
  parameter int TICKS_PER_SECOND = cth_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // cold_enabled, manual_test, fill_done, cold_fault, air_fault,
  // power_mode[1:0], cold_temp[11:0], air_temp[11:0], zero pad
  input  logic [cth_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // compressor_on, run_step[2:0], restart_ready, max_on_reached,
  // overrun_left[15:0], zero pad
  output logic [cth_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                             cfg_wen,
  input  logic [cth_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [cth_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  cth_pkg::cfg_t    cfg;
  cth_pkg::tick_t   in_tick;
  cth_pkg::result_t res, out_res;
  logic             in_valid;
  logic             advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_temp_normal <= cth_pkg::START_NORMAL_RST;
      cfg.start_temp_saving <= cth_pkg::START_SAVING_RST;
      cfg.stop_temp         <= cth_pkg::STOP_TEMP_RST;
      cfg.overrun_mild      <= cth_pkg::OVERRUN_MILD_RST;
      cfg.overrun_hot       <= cth_pkg::OVERRUN_HOT_RST;
      cfg.restart_delay     <= cth_pkg::RESTART_DELAY_RST;
      cfg.max_on_time       <= cth_pkg::MAX_ON_TIME_RST;
      cfg.ice_guard_temp    <= cth_pkg::ICE_GUARD_RST;
    end else if (cfg_wen) begin
      unique case (cth_pkg::reg_idx_t'(cfg_addr))
        cth_pkg::REG_START_NORMAL:  cfg.start_temp_normal <= cfg_wdata[cth_pkg::TEMP_W-1:0];
        cth_pkg::REG_START_SAVING:  cfg.start_temp_saving <= cfg_wdata[cth_pkg::TEMP_W-1:0];
        cth_pkg::REG_STOP_TEMP:     cfg.stop_temp         <= cfg_wdata[cth_pkg::TEMP_W-1:0];
        cth_pkg::REG_OVERRUN_MILD:  cfg.overrun_mild      <= cfg_wdata;
        cth_pkg::REG_OVERRUN_HOT:   cfg.overrun_hot       <= cfg_wdata;
        cth_pkg::REG_RESTART_DELAY: cfg.restart_delay     <= cfg_wdata;
        cth_pkg::REG_MAX_ON_TIME:   cfg.max_on_time       <= cfg_wdata;
        cth_pkg::REG_ICE_GUARD:     cfg.ice_guard_temp    <= cfg_wdata[cth_pkg::TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_tick <= cth_pkg::tick_t'(s_tdata[cth_pkg::TICK_W-1:0]);
    end
  end

  cth_ctrl #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .tick (in_tick),
    .cfg  (cfg),
    .res  (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {(cth_pkg::M_TDATA_W - cth_pkg::RESULT_W)'(0), out_res};

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed tick produced no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("request refused with empty input register");

  a_tick_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("pending tick dropped");

endmodule

>>> test/compressor_thermostat_control_tb.sv
// ----------------------------------------------------------------------------
// Compressor thermostat control testbench
// Drives 100 ms ticks into the stream input and predicts every result with
// its own model of the thermostat: the seconds counters, the restart delay,
// the on-time cap, the ice guard, the air steps and the overrun. Results are
// compared field by field in order. The run starts with a short directed
// table, then random phases under several register settings, extremes
// included, with random idling on both sides but for the closing phase.
// ----------------------------------------------------------------------------
module compressor_thermostat_control_tb;
  import cth_pkg::*;

  localparam int RESET_ROWS = 8;
  localparam int AIR_EDGES[6] = '{99, 100, 199, 200, 299, 300};

  typedef struct packed {
    tick_t   t;
    logic    fixed;
    result_t res;
  } row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  // cold_enabled, manual_test, fill_done, cold_fault, air_fault,
  // power_mode[1:0], cold_temp[11:0], air_temp[11:0], zero pad
  logic [S_TDATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  // compressor_on, run_step[2:0], restart_ready, max_on_reached,
  // overrun_left[15:0], zero pad
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_wen;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Thermostat state as the block should hold it
  cfg_t              cfg;
  logic              comp_on;
  logic [3:0]        presc;
  logic [CNT_W-1:0]  off_sec;
  logic [CNT_W-1:0]  on_sec;
  logic [CNT_W-1:0]  ovr;
  logic [STEP_W-1:0] step;

  result_t due_results[$];
  row_t    dir_rows[$];
  bit      idle_on;
  int      fail_cnt;
  int      ticks_sent;
  int      results_seen;
  int      settings_used;

  compressor_thermostat_control dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("compressor_thermostat_control test failed");
    $finish;
  end

  function automatic void drop_compressor();
    if (comp_on) begin
      comp_on = 1'b0;
      off_sec = '0;
      ovr     = '0;
    end
  endfunction

  function automatic result_t thermostat_tick(tick_t t);
    result_t r;
    logic signed [TEMP_W-1:0] cold;
    logic signed [TEMP_W-1:0] air;
    logic signed [TEMP_W-1:0] start;
    cold = t.cold_temp;
    air  = t.air_temp;
    // Seconds counters use the compressor state from before the tick
    presc = presc + 4'd1;
    if (presc >= TICKS_PER_SECOND_DEF) begin
      presc = '0;
      if (!comp_on) begin
        if (off_sec < cfg.restart_delay) off_sec = off_sec + 1'b1;
        on_sec = '0;
      end else if (on_sec < cfg.max_on_time) begin
        on_sec = on_sec + 1'b1;
        if (cold < $signed(cfg.ice_guard_temp)) on_sec = cfg.max_on_time;
      end
    end
    if (!t.manual_test) begin
      if (!t.cold_enabled) begin
        drop_compressor();
      end else if (off_sec < cfg.restart_delay) begin
        // off time is kept here, unlike the other forced stops
        ovr     = '0;
        comp_on = 1'b0;
      end else if (on_sec >= cfg.max_on_time) begin
        drop_compressor();
      end else if (!t.fill_done) begin
        drop_compressor();
      end else begin
        if (t.air_fault) step = STEP_FAULT;
        else if (air < AIR_LIMIT_COOL) step = STEP_COOL;
        else if (air < AIR_LIMIT_MILD) step = STEP_MILD;
        else if (air < AIR_LIMIT_WARM) step = STEP_WARM;
        else step = STEP_HOT;
        if (step > STEP_MAX) step = STEP_MAX;
        if (t.cold_fault) begin
          drop_compressor();
        end else begin
          start = (t.power_mode == POWER_NORMAL) ? $signed(cfg.start_temp_normal)
                                                 : $signed(cfg.start_temp_saving);
          if (cold > start) begin
            if (!comp_on) begin
              comp_on = 1'b1;
              if (step == STEP_COOL || step == STEP_MILD) ovr = cfg.overrun_mild;
              else if (step >= STEP_WARM) ovr = cfg.overrun_hot;
              else ovr = '0;
            end
          end else if (cold < $signed(cfg.stop_temp)) begin
            if (comp_on) begin
              if (ovr == '0) begin
                off_sec = '0;
                comp_on = 1'b0;
              end else begin
                ovr = ovr - 1'b1;
              end
            end
          end
        end
      end
    end
    r.compressor_on  = comp_on;
    r.run_step       = step;
    r.restart_ready  = (off_sec >= cfg.restart_delay);
    r.max_on_reached = (on_sec >= cfg.max_on_time);
    r.overrun_left   = ovr;
    return r;
  endfunction

  function automatic tick_t mk_tick(bit en, bit man, bit fill, bit cf, bit af, int pm,
                                    int cold, int air);
    tick_t t;
    t.cold_enabled = en;
    t.manual_test  = man;
    t.fill_done    = fill;
    t.cold_fault   = cf;
    t.air_fault    = af;
    t.power_mode   = 2'(pm);
    t.cold_temp    = TEMP_W'(cold);
    t.air_temp     = TEMP_W'(air);
    return t;
  endfunction

  // Mostly enabled, healthy ticks with the tank hovering around the thresholds
  function automatic tick_t rand_tick();
    tick_t t;
    int lo;
    int hi;
    int sel;
    lo = $signed(cfg.start_temp_normal);
    hi = lo;
    if ($signed(cfg.start_temp_saving) < lo) lo = $signed(cfg.start_temp_saving);
    if ($signed(cfg.start_temp_saving) > hi) hi = $signed(cfg.start_temp_saving);
    if ($signed(cfg.stop_temp) < lo) lo = $signed(cfg.stop_temp);
    if ($signed(cfg.stop_temp) > hi) hi = $signed(cfg.stop_temp);
    if ($signed(cfg.ice_guard_temp) < lo) lo = $signed(cfg.ice_guard_temp);
    if ($signed(cfg.ice_guard_temp) > hi) hi = $signed(cfg.ice_guard_temp);
    lo = lo - 30;
    hi = hi + 30;
    if (lo < -2048) lo = -2048;
    if (hi > 2047) hi = 2047;
    t.cold_enabled = ($urandom_range(0, 19) != 0);
    t.manual_test  = ($urandom_range(0, 19) == 0);
    t.fill_done    = ($urandom_range(0, 19) != 0);
    t.cold_fault   = ($urandom_range(0, 24) == 0);
    t.air_fault    = ($urandom_range(0, 9) == 0);
    t.power_mode   = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) t.cold_temp = TEMP_W'($urandom);
    else t.cold_temp = TEMP_W'(lo + int'($urandom_range(0, hi - lo)));
    sel = $urandom_range(0, 9);
    if (sel == 0) t.air_temp = TEMP_W'($urandom);
    else if (sel == 1) t.air_temp = TEMP_W'(AIR_EDGES[$urandom_range(0, 5)]);
    else t.air_temp = TEMP_W'(-500 + int'($urandom_range(0, 2000)));
    return t;
  endfunction

  // Register settings per phase: -1 for the directed table, 0 and 1 extremes
  function automatic cfg_t pick_settings(int ph);
    cfg_t c;
    case (ph)
      -1: begin
        c.start_temp_normal = 12'sd80;
        c.start_temp_saving = 12'sd100;
        c.stop_temp         = 12'sd60;
        c.overrun_mild      = 16'd2;
        c.overrun_hot       = 16'd3;
        c.restart_delay     = 16'd0;
        c.max_on_time       = 16'd4;
        c.ice_guard_temp    = -12'sd2048;
      end
      0: begin
        c.start_temp_normal = -12'sd2048;
        c.start_temp_saving = 12'sd2047;
        c.stop_temp         = 12'sd2047;
        c.overrun_mild      = 16'hFFFF;
        c.overrun_hot       = 16'd0;
        c.restart_delay     = 16'd0;
        c.max_on_time       = 16'hFFFF;
        c.ice_guard_temp    = -12'sd2048;
      end
      1: begin
        c.start_temp_normal = 12'sd2047;
        c.start_temp_saving = -12'sd2048;
        c.stop_temp         = -12'sd2048;
        c.overrun_mild      = 16'd0;
        c.overrun_hot       = 16'hFFFF;
        c.restart_delay     = 16'hFFFF;
        c.max_on_time       = 16'd0;
        c.ice_guard_temp    = 12'sd2047;
      end
      default: begin
        c.start_temp_normal = TEMP_W'(-20 + int'($urandom_range(0, 220)));
        c.start_temp_saving = TEMP_W'(-20 + int'($urandom_range(0, 220)));
        c.stop_temp         = TEMP_W'(-50 + int'($urandom_range(0, 170)));
        c.overrun_mild      = CNT_W'($urandom_range(0, 20));
        c.overrun_hot       = CNT_W'($urandom_range(0, 40));
        c.restart_delay     = CNT_W'($urandom_range(0, 3));
        c.max_on_time       = ($urandom_range(0, 5) == 0) ? '0 : CNT_W'($urandom_range(1, 8));
        c.ice_guard_temp    = TEMP_W'(-60 + int'($urandom_range(0, 120)));
      end
    endcase
    return c;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Hold the sender until every result is back, then rewrite all registers
  task automatic apply_settings(cfg_t c);
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_START_NORMAL,  CFG_DATA_W'($signed(c.start_temp_normal)));
    write_reg(REG_START_SAVING,  CFG_DATA_W'($signed(c.start_temp_saving)));
    write_reg(REG_STOP_TEMP,     CFG_DATA_W'($signed(c.stop_temp)));
    write_reg(REG_OVERRUN_MILD,  c.overrun_mild);
    write_reg(REG_OVERRUN_HOT,   c.overrun_hot);
    write_reg(REG_RESTART_DELAY, c.restart_delay);
    write_reg(REG_MAX_ON_TIME,   c.max_on_time);
    write_reg(REG_ICE_GUARD,     CFG_DATA_W'($signed(c.ice_guard_temp)));
    cfg_wen <= 1'b0;
    cfg = c;
    settings_used++;
  endtask

  task automatic send_tick(tick_t t, logic fixed, result_t res);
    result_t pred;
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'(t);
    do @(posedge clk); while (!s_tready);
    pred = thermostat_tick(t);
    due_results.push_back(fixed ? res : pred);
    ticks_sent++;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Receiver: random stall bursts while idling is on
  initial begin
    int hold;
    hold = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(0, 16);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[RESULT_W-1:0]);
      if (due_results.size() == 0) begin
        $error("result with no tick outstanding: %h", m_tdata);
        fail_cnt++;
      end else begin
        want = due_results.pop_front();
        check_field("compressor_on", want.compressor_on, got.compressor_on);
        check_field("run_step", want.run_step, got.run_step);
        check_field("restart_ready", want.restart_ready, got.restart_ready);
        check_field("max_on_reached", want.max_on_reached, got.max_on_reached);
        check_field("overrun_left", want.overrun_left, got.overrun_left);
        results_seen++;
      end
    end
  end

  initial begin
    int n;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_wen   <= 1'b0;
    cfg_addr  <= REG_START_NORMAL;
    cfg_wdata <= '0;
    idle_on       = 1'b1;
    fail_cnt      = 0;
    ticks_sent    = 0;
    results_seen  = 0;
    settings_used = 1;
    cfg.start_temp_normal = START_NORMAL_RST;
    cfg.start_temp_saving = START_SAVING_RST;
    cfg.stop_temp         = STOP_TEMP_RST;
    cfg.overrun_mild      = OVERRUN_MILD_RST;
    cfg.overrun_hot       = OVERRUN_HOT_RST;
    cfg.restart_delay     = RESTART_DELAY_RST;
    cfg.max_on_time       = MAX_ON_TIME_RST;
    cfg.ice_guard_temp    = ICE_GUARD_RST;
    comp_on = 1'b0;
    presc   = '0;
    off_sec = '0;
    on_sec  = '0;
    ovr     = '0;
    step    = STEP_FAULT;

    // At reset the restart delay is far off, so every result is all zero
    dir_rows.push_back('{mk_tick(1, 0, 1, 0, 0, 0, 2047, 2047), 1'b1, '0});
    dir_rows.push_back('{mk_tick(1, 0, 1, 0, 0, 3, -2048, -2048), 1'b1, '0});
    dir_rows.push_back('{mk_tick(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
    dir_rows.push_back('{mk_tick(1, 1, 1, 1, 1, 2, 2047, -2048), 1'b1, '0});
    dir_rows.push_back('{mk_tick(1, 0, 0, 0, 0, 1, 500, 150), 1'b1, '0});
    dir_rows.push_back('{mk_tick(1, 0, 1, 1, 0, 0, 1500, 250), 1'b1, '0});
    dir_rows.push_back('{mk_tick(1, 0, 1, 0, 1, 0, -500, 1500), 1'b1, '0});
    dir_rows.push_back('{mk_tick(0, 1, 0, 1, 1, 3, -2048, 2047), 1'b1, '0});
    // No restart delay, short overrun: start, count down, stop
    dir_rows.push_back('{mk_tick(1, 0, 1, 0, 0, 0, 200, 50), 1'b0, '0});
    dir_rows.push_back('{mk_tick(1, 0, 1, 0, 0, 0, 0, 100), 1'b0, '0});
    dir_rows.push_back('{mk_tick(1, 0, 1, 0, 0, 1, 0, 199), 1'b0, '0});
    dir_rows.push_back('{mk_tick(1, 0, 1, 0, 0, 2, 0, 200), 1'b0, '0});
    // Saving mode three, below and then above its start threshold
    dir_rows.push_back('{mk_tick(1, 0, 1, 0, 0, 3, 90, 299), 1'b0, '0});
    dir_rows.push_back('{mk_tick(1, 0, 1, 0, 0, 3, 101, 300), 1'b0, '0});
    dir_rows.push_back('{mk_tick(1, 1, 0, 1, 1, 0, -2048, 0), 1'b0, '0});
    dir_rows.push_back('{mk_tick(1, 0, 1, 0, 1, 0, 2047, 0), 1'b0, '0});
    dir_rows.push_back('{mk_tick(1, 0, 1, 1, 0, 0, 2047, 50), 1'b0, '0});
    // Start on a faulty air sensor loads no overrun
    dir_rows.push_back('{mk_tick(1, 0, 1, 0, 1, 0, 2047, 50), 1'b0, '0});
    dir_rows.push_back('{mk_tick(1, 0, 1, 0, 0, 0, -2048, -2048), 1'b0, '0});
    dir_rows.push_back('{mk_tick(1, 0, 1, 0, 0, 0, 81, 1500), 1'b0, '0});
    dir_rows.push_back('{mk_tick(0, 0, 1, 0, 0, 0, 81, 1500), 1'b0, '0});
    dir_rows.push_back('{mk_tick(1, 0, 1, 0, 0, 0, 81, 1500), 1'b0, '0});
    dir_rows.push_back('{mk_tick(1, 0, 0, 0, 0, 0, 81, 1500), 1'b0, '0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      if (k == RESET_ROWS) apply_settings(pick_settings(-1));
      send_tick(dir_rows[k].t, dir_rows[k].fixed, dir_rows[k].res);
    end

    for (int ph = 0; ph < 6; ph++) begin
      apply_settings(pick_settings(ph));
      // Drop idling for the closing phase
      if (ph == 5) idle_on = 1'b0;
      n = (ph == 1) ? 60 : 214;
      repeat (n) send_tick(rand_tick(), 1'b0, '0);
    end

    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d ticks under %0d register settings, %0d results compared",
             ticks_sent, settings_used, results_seen);
    if (fail_cnt == 0) begin
      $display("compressor_thermostat_control test passed");
    end else begin
      $display("compressor_thermostat_control test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/cth_pkg.sv
design/cth_ctrl.sv
design/compressor_thermostat_control.sv
test/compressor_thermostat_control_tb.sv
